@@ hdl/tcw_pkg.sv @@
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  // Widths derived from the geometry.
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS) + 1;
  localparam int SUM_W    = COL_W + 5;
  localparam int CELL_W   = 16;
  localparam int CURSOR_W = 11;

  // Character codes with special meaning.
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_NONE      = 8'd0;

  // Tab steps are capped at this many cells.
  localparam logic [4:0] TAB_LIMIT = 5'd16;

  // Register reset values.
  localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;
  localparam logic [4:0] TAB_STEP_RESET     = 5'd4;

  // Configuration register indexes.
  localparam logic CFG_DEFAULT_ATTRIBUTE = 1'b0;
  localparam logic CFG_TAB_STEP          = 1'b1;

  // Action codes.
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_RD_WAIT,
    S_BS_CHK,
    S_ATTR_RD,
    S_ATTR_WR,
    S_SCROLL,
    S_ZERO,
    S_FINISH
  } state_t;

  // Linear cell index of a row and column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row * COLUMNS + col);
  endfunction

endpackage

@@ hdl/tcw_ram.sv @@
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/text_console_cell_writer.sv @@
// Text console with a ROWS x COLUMNS cell store (character in the low byte, attribute in
// the high byte of each cell) and a cursor, built around one synchronous RAM with a
// registered read port. Items are taken one at a time. A read item reads the cell and
// waits for the registered data before its result; a put of an ordinary character,
// newline or tab writes the target cell, then does a read-modify-write of the attribute
// at the new cursor; a backspace writes its cell, then scans back over space cells.
// An ignored put, a read off the screen and a backspace at cell zero go straight to
// the result. A put that runs past the last cell scrolls the store, which replaces the
// attribute write, one scrolled row at a time on the single RAM port pair. After reset a
// clearing pass writes zero to all CELLS entries, one per cycle, before the first item
// is taken; configuration writes are taken at any time.
module text_console_cell_writer
  import tcw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Configuration write port.
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  // Item input.
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic [7:0]          character,
  input  logic                use_position,
  input  logic [6:0]          column,
  input  logic [4:0]          line,
  input  logic [7:0]          attribute,
  // Result output.
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CURSOR_W-1:0] cursor_cell,
  output logic [7:0]          cell_character,
  output logic [7:0]          cell_attribute
);

  state_t state, state_next;

  // Configuration and cursor.
  logic [7:0]       default_attribute;
  logic [4:0]       tab_step;
  logic [ROW_W-1:0] cursor_row;
  logic [COL_W-1:0] cursor_col;

  // Captured item.
  logic             it_action;
  logic             it_put;
  logic             it_range;
  logic [7:0]       it_char;
  logic [7:0]       it_attr;
  logic [ROW_W-1:0] pos_row;
  logic [COL_W-1:0] pos_col;

  // Working positions.
  logic [ROW_W-1:0] nxt_row;
  logic [COL_W-1:0] nxt_col;
  logic [ROW_W-1:0] scan_row;
  logic [COL_W-1:0] scan_col;
  logic [7:0]       rd_char;
  logic [7:0]       rd_attr;

  // Sweep counter shared by clearing and scrolling.
  logic [ADDR_W-1:0] sc_cnt;
  logic              sc_pend;
  logic [ADDR_W-1:0] sc_wr;

  // RAM port.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Derived values.
  logic             in_range;
  logic [4:0]       tab_eff;
  logic [SUM_W-1:0] tab_sum;
  logic             pos_zero;
  logic [ROW_W-1:0] pm1_row;
  logic [COL_W-1:0] pm1_col;
  logic             scan_nz;
  logic [ROW_W-1:0] sm1_row;
  logic [COL_W-1:0] sm1_col;
  logic [7:0]       rd_byte;
  logic             scan_more;
  logic             scan_mark;
  logic             nxt_past;
  logic             dec_past;
  logic             sweep_end;
  logic             copy_end;
  logic             fin_go;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Position checks and small arithmetic on the captured item.
  assign in_range  = (32'(column) < COLUMNS) && (32'(line) < ROWS);
  assign tab_eff   = (tab_step > TAB_LIMIT) ? TAB_LIMIT : tab_step;
  assign tab_sum   = SUM_W'(pos_col) + SUM_W'(tab_eff);
  assign pos_zero  = (pos_row == '0) && (pos_col == '0);
  assign pm1_row   = (pos_col == '0) ? pos_row - 1'b1 : pos_row;
  assign pm1_col   = (pos_col == '0) ? COL_W'(COLUMNS - 1) : pos_col - 1'b1;
  assign scan_nz   = (scan_row != '0) || (scan_col != '0);
  assign sm1_row   = (scan_col == '0) ? scan_row - 1'b1 : scan_row;
  assign sm1_col   = (scan_col == '0) ? COL_W'(COLUMNS - 1) : scan_col - 1'b1;
  assign rd_byte   = ram_rdata[7:0];
  assign scan_more = scan_nz && (rd_byte == CH_SPACE);
  assign scan_mark = (rd_byte == CH_NEWLINE) || (rd_byte == CH_TAB);
  assign nxt_past  = 32'(nxt_row) >= ROWS;
  assign dec_past  = 32'(nxt_row - 1'b1) >= ROWS;
  assign sweep_end = sc_cnt == ADDR_W'(CELLS - 1);
  assign copy_end  = sc_cnt == ADDR_W'(CELLS - COLUMNS);
  assign fin_go    = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sweep_end) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_START;
      end
      S_START: begin
        priority if (it_action == ACT_READ && it_range) state_next = S_RD_WAIT;
        else if (!it_put) state_next = S_FINISH;
        else if (it_char == CH_BACKSPACE) state_next = pos_zero ? S_FINISH : S_BS_CHK;
        else state_next = S_ATTR_RD;
      end
      S_RD_WAIT: state_next = S_FINISH;
      S_BS_CHK: begin
        if (!scan_more) state_next = S_FINISH;
      end
      S_ATTR_RD: state_next = nxt_past ? S_SCROLL : S_ATTR_WR;
      S_ATTR_WR: state_next = S_FINISH;
      S_SCROLL: begin
        if (copy_end) state_next = S_ZERO;
      end
      S_ZERO: begin
        if (sweep_end) state_next = dec_past ? S_SCROLL : S_FINISH;
      end
      S_FINISH: begin
        if (fin_go) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Handshake and RAM port controls.
  always_comb begin
    in_ready  = (state == S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = cell_addr(pos_row, pos_col);
    ram_wdata = '0;
    ram_raddr = cell_addr(pos_row, pos_col);
    unique case (state)
      S_CLEAR, S_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = sc_cnt;
      end
      S_START: begin
        if (it_put) begin
          ram_we = 1'b1;
          unique case (it_char)
            CH_BACKSPACE: begin
              ram_wdata = pos_zero ? {it_attr, CH_SPACE} : {8'd0, CH_SPACE};
              ram_raddr = cell_addr(pm1_row, pm1_col);
            end
            CH_NEWLINE, CH_TAB: ram_wdata = {8'd0, it_char};
            default:            ram_wdata = {it_attr, it_char};
          endcase
        end
      end
      S_BS_CHK: begin
        ram_raddr = cell_addr(sm1_row, sm1_col);
        if (!scan_more) begin
          ram_we    = 1'b1;
          ram_wdata = {it_attr, CH_SPACE};
          ram_waddr = scan_mark ? cell_addr(scan_row, scan_col) : cell_addr(pm1_row, pm1_col);
        end
      end
      S_ATTR_RD: ram_raddr = cell_addr(nxt_row, nxt_col);
      S_ATTR_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(nxt_row, nxt_col);
        ram_wdata = {it_attr, rd_byte};
      end
      S_SCROLL: begin
        ram_raddr = ADDR_W'(sc_cnt + COLUMNS);
        ram_we    = sc_pend;
        ram_waddr = sc_wr;
        ram_wdata = ram_rdata;
      end
      S_IDLE, S_RD_WAIT, S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLEAR;
      default_attribute <= DEFAULT_ATTR_RESET;
      tab_step          <= TAB_STEP_RESET;
      cursor_row        <= '0;
      cursor_col        <= '0;
      out_valid         <= 1'b0;
      sc_cnt            <= '0;
      sc_pend           <= 1'b0;
    end else begin
      state <= state_next;

      // Configuration writes.
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_DEFAULT_ATTRIBUTE: default_attribute <= cfg_data;
          CFG_TAB_STEP:          tab_step <= cfg_data[4:0];
          default:               tab_step <= tab_step;
        endcase
      end

      // Sweep counter for the clearing pass and for scrolling.
      unique case (state)
        S_CLEAR, S_ZERO: sc_cnt <= sweep_end ? '0 : ADDR_W'(sc_cnt + 1'b1);
        S_ATTR_RD: begin
          sc_cnt  <= '0;
          sc_pend <= 1'b0;
        end
        S_SCROLL: begin
          if (copy_end) begin
            sc_pend <= 1'b0;
          end else begin
            sc_pend <= 1'b1;
            sc_cnt  <= ADDR_W'(sc_cnt + 1'b1);
          end
        end
        default: sc_pend <= 1'b0;
      endcase

      // Result register and cursor update.
      if (state == S_FINISH && fin_go) begin
        out_valid  <= 1'b1;
        cursor_row <= nxt_row;
        cursor_col <= nxt_col;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and working registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      it_action <= action;
      it_char   <= character;
      it_attr   <= (attribute == 8'd0) ? default_attribute : attribute;
      it_range  <= in_range;
      it_put    <= (action == ACT_PUT) && (character != CH_NONE) && (!use_position || in_range);
      // Reads always address the given cell; puts may use the cursor.
      pos_row   <= (use_position || action == ACT_READ) ? ROW_W'(line) : cursor_row;
      pos_col   <= (use_position || action == ACT_READ) ? COL_W'(column) : cursor_col;
    end

    unique case (state)
      S_START: begin
        rd_char <= 8'd0;
        rd_attr <= 8'd0;
        nxt_row <= cursor_row;
        nxt_col <= cursor_col;
        scan_row <= pm1_row;
        scan_col <= pm1_col;
        if (it_put) begin
          unique case (it_char)
            CH_NEWLINE: begin
              nxt_row <= pos_row + 1'b1;
              nxt_col <= '0;
            end
            CH_BACKSPACE: begin
              nxt_row <= '0;
              nxt_col <= '0;
            end
            CH_TAB: begin
              priority if (tab_sum >= SUM_W'(2 * COLUMNS)) begin
                nxt_row <= pos_row + ROW_W'(2);
                nxt_col <= COL_W'(tab_sum - SUM_W'(2 * COLUMNS));
              end else if (tab_sum >= SUM_W'(COLUMNS)) begin
                nxt_row <= pos_row + 1'b1;
                nxt_col <= COL_W'(tab_sum - SUM_W'(COLUMNS));
              end else begin
                nxt_row <= pos_row;
                nxt_col <= COL_W'(tab_sum);
              end
            end
            default: begin
              if (pos_col == COL_W'(COLUMNS - 1)) begin
                nxt_row <= pos_row + 1'b1;
                nxt_col <= '0;
              end else begin
                nxt_row <= pos_row;
                nxt_col <= pos_col + 1'b1;
              end
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        rd_char <= ram_rdata[7:0];
        rd_attr <= ram_rdata[15:8];
      end
      S_BS_CHK: begin
        // Walk back over spaces, one cell per cycle.
        if (scan_more) begin
          scan_row <= sm1_row;
          scan_col <= sm1_col;
        end else if (scan_mark) begin
          nxt_row <= scan_row;
          nxt_col <= scan_col;
        end else begin
          nxt_row <= pm1_row;
          nxt_col <= pm1_col;
        end
      end
      S_SCROLL: begin
        sc_wr <= sc_cnt;
      end
      S_ZERO: begin
        if (sweep_end) nxt_row <= nxt_row - 1'b1;
      end
      default: begin
      end
    endcase

    // Result payload.
    if (state == S_FINISH && fin_go) begin
      cursor_cell    <= CURSOR_W'(cell_addr(nxt_row, nxt_col));
      cell_character <= rd_char;
      cell_attribute <= rd_attr;
    end
  end

endmodule

@@ hdl/tcw_checker.sv @@
module tcw_checker
  import tcw_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [CURSOR_W-1:0] cursor_cell,
  input logic [7:0]          cell_character,
  input logic [7:0]          cell_attribute
);

  // A result that waits keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor_cell) &&
      $stable(cell_character) && $stable(cell_attribute))
    else $error("result changed while waiting for transfer");

  // Reset starts the clearing pass with no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block ready or result pending right after reset");

  // Items are worked on one at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  // The cursor of a valid result always lies on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor_cell < CURSOR_W'(CELLS))
    else $error("cursor outside the screen");

endmodule

bind text_console_cell_writer tcw_checker u_checker (.*);
